[rtl/rc4_pkg.sv]
package rc4_pkg;

	// Key storage is fixed by the two 64-bit key words
	localparam int KEY_BYTES = 16;
	localparam int KeyLenW   = 5;
	localparam int KeyIdxW   = 4;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 64;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_KEY_LEN  = 2'd2;

	// Request opcodes
	localparam logic OP_KEY_SCHED = 1'b0;
	localparam logic OP_CRYPT     = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KS_RD_I,
		ST_KS_RD_J,
		ST_KS_WR_I,
		ST_KS_WR_J,
		ST_B_RD_I,
		ST_B_RD_J,
		ST_B_WR_I,
		ST_B_WR_J,
		ST_B_RD_K,
		ST_B_OUT
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_INIT_WR,
		DP_KS_RD_I,
		DP_KS_RD_J,
		DP_KS_WR_I,
		DP_KS_WR_J,
		DP_B_RD_I,
		DP_B_RD_J,
		DP_B_WR_I,
		DP_B_WR_J,
		DP_B_RD_K,
		DP_B_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic n_last;    // table counter at its last entry
		logic out_free;  // output register can take a result
	} dp_stat_t;

endpackage

[rtl/rc4_req_if.sv]
interface rc4_req_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_in;
	logic       last_in;

	modport source (output valid, output op, output data_in, output last_in, input ready);
	modport sink (input valid, input op, input data_in, input last_in, output ready);
endinterface

[rtl/rc4_rsp_if.sv]
interface rc4_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic       last_out;

	modport source (output valid, output data_out, output last_out, input ready);
	modport sink (input valid, input data_out, input last_out, output ready);
endinterface

[rtl/rc4_ctrl.sv]
module rc4_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_op,
	output logic              req_ready,
	input  rc4_pkg::dp_stat_t stat,
	output rc4_pkg::dp_cmd_t  cmd
);
	import rc4_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d   = state_q;
		cmd.op    = DP_NOP;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = DP_LOAD;
					state_d = (req_op == OP_CRYPT) ? ST_B_RD_I : ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.op = DP_INIT_WR;
				if (stat.n_last) state_d = ST_KS_RD_I;
			end
			ST_KS_RD_I: begin
				cmd.op  = DP_KS_RD_I;
				state_d = ST_KS_RD_J;
			end
			ST_KS_RD_J: begin
				cmd.op  = DP_KS_RD_J;
				state_d = ST_KS_WR_I;
			end
			ST_KS_WR_I: begin
				cmd.op  = DP_KS_WR_I;
				state_d = ST_KS_WR_J;
			end
			ST_KS_WR_J: begin
				cmd.op  = DP_KS_WR_J;
				state_d = stat.n_last ? ST_IDLE : ST_KS_RD_I;
			end
			ST_B_RD_I: begin
				cmd.op  = DP_B_RD_I;
				state_d = ST_B_RD_J;
			end
			ST_B_RD_J: begin
				cmd.op  = DP_B_RD_J;
				state_d = ST_B_WR_I;
			end
			ST_B_WR_I: begin
				cmd.op  = DP_B_WR_I;
				state_d = ST_B_WR_J;
			end
			ST_B_WR_J: begin
				cmd.op  = DP_B_WR_J;
				state_d = ST_B_RD_K;
			end
			ST_B_RD_K: begin
				cmd.op  = DP_B_RD_K;
				state_d = ST_B_OUT;
			end
			ST_B_OUT: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.op  = DP_B_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/rc4_datapath.sv]
module rc4_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rc4_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [rc4_pkg::CfgDataW-1:0]  cfg_data,
	input  logic [7:0]                    req_data_in,
	input  logic                          req_last_in,
	input  logic                          rsp_ready,
	output logic                          rsp_valid,
	output logic [7:0]                    rsp_data_out,
	output logic                          rsp_last_out,
	input  rc4_pkg::dp_cmd_t              cmd,
	output rc4_pkg::dp_stat_t             stat
);
	import rc4_pkg::*;

	logic [CfgDataW-1:0] key_low_q, key_high_q;
	logic [KeyLenW-1:0]  key_len_q, eff_len;
	logic [KeyIdxW-1:0]  kidx_q, kidx_nxt;
	logic [2*CfgDataW-1:0] key_vec;
	logic [7:0]          key_byte;

	logic [7:0] n_q, i_q, j_q, si_q, sj_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;

	logic [7:0] perm_mem [256];
	logic [7:0] rd_data_q;
	logic       rd_en, wr_en;
	logic [7:0] rd_addr, wr_addr, wr_data;
	logic [7:0] j_ks, j_b, i_nxt;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= KeyLenW'(KEY_BYTES);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LEN:  key_len_q  <= cfg_data[KeyLenW-1:0];
				default: ;
			endcase
		end
	end

	// Effective key length: zero counts as one, saturate at the key size
	always_comb begin
		eff_len = key_len_q;
		if (key_len_q == '0) eff_len = KeyLenW'(1);
		else if (key_len_q > KeyLenW'(KEY_BYTES)) eff_len = KeyLenW'(KEY_BYTES);
	end

	assign key_vec  = {key_high_q, key_low_q};
	assign key_byte = key_vec[kidx_q*8 +: 8];
	assign kidx_nxt = ({1'b0, kidx_q} + KeyLenW'(1) == eff_len) ? '0 : kidx_q + KeyIdxW'(1);

	assign j_ks  = j_q + rd_data_q + key_byte;
	assign j_b   = j_q + rd_data_q;
	assign i_nxt = i_q + 8'd1;

	// Memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = n_q;
		wr_en   = 1'b0;
		wr_addr = n_q;
		wr_data = n_q;
		case (cmd.op)
			DP_INIT_WR: wr_en = 1'b1;
			DP_KS_RD_I: rd_en = 1'b1;
			DP_KS_RD_J: begin
				rd_en   = 1'b1;
				rd_addr = j_ks;
			end
			DP_KS_WR_I: begin
				wr_en   = 1'b1;
				wr_data = rd_data_q;
			end
			DP_KS_WR_J: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = si_q;
			end
			DP_B_RD_I: begin
				rd_en   = 1'b1;
				rd_addr = i_nxt;
			end
			DP_B_RD_J: begin
				rd_en   = 1'b1;
				rd_addr = j_b;
			end
			DP_B_WR_I: begin
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = rd_data_q;
			end
			DP_B_WR_J: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = si_q;
			end
			DP_B_RD_K: begin
				rd_en   = 1'b1;
				rd_addr = si_q + sj_q;
			end
			default: ;
		endcase
	end

	// Permutation table: one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) perm_mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= perm_mem[rd_addr];
	end

	// Indices, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			kidx_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result flag: set on a new result, cleared once taken
			if (cmd.op == DP_B_OUT) out_valid_q <= 1'b1;
			else if (out_valid_q && rsp_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				DP_LOAD: begin
					n_q    <= '0;
					kidx_q <= '0;
				end
				DP_INIT_WR: begin
					n_q <= n_q + 8'd1;
					j_q <= '0;
				end
				DP_KS_RD_J: j_q <= j_ks;
				DP_KS_WR_J: begin
					n_q    <= n_q + 8'd1;
					kidx_q <= kidx_nxt;
					if (n_q == 8'hff) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				DP_B_RD_I: i_q <= i_nxt;
				DP_B_RD_J: j_q <= j_b;
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				data_q <= req_data_in;
				last_q <= req_last_in;
			end
			DP_KS_RD_J, DP_B_RD_J: si_q <= rd_data_q;
			DP_KS_WR_I, DP_B_WR_I: sj_q <= rd_data_q;
			DP_B_OUT: begin
				out_data_q <= data_q ^ rd_data_q;
				out_last_q <= last_q;
			end
			default: ;
		endcase
	end

	assign stat.n_last   = (n_q == 8'hff);
	assign stat.out_free = !out_valid_q || rsp_ready;

	assign rsp_valid    = out_valid_q;
	assign rsp_data_out = out_data_q;
	assign rsp_last_out = out_last_q;

endmodule

[rtl/rc4_keystream_cipher.sv]
// Channel  | Dir | Payload             | Meaning
// req      | in  | op, data_in, last_in| key schedule (op 0) or one data byte (op 1)
// rsp      | out | data_out, last_out  | data byte XOR keystream, one per op 1 request
// cfg      | in  | cfg_we/index/data   | key words (0, 1) and key length (2)
//
// A data byte passes through the accept state, reads of S[i] and S[j], two swap
// writes, a read of S[S[i]+S[j]] and the output step; a key schedule fills the
// table, then reads and writes two entries per swap, as set by the single read
// and write port of the 256-entry permutation RAM. Reset clears indices, control
// and key words and sets the key length to 16; the table holds garbage until a
// key schedule runs. A result waits in the output register; a second data
// request stalls only in its last step while that register is still full.
module rc4_keystream_cipher (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rc4_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [rc4_pkg::CfgDataW-1:0] cfg_data,
	rc4_req_if.sink                      req,
	rc4_rsp_if.source                    rsp
);
	import rc4_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.op),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rc4_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_data_in  (req.data_in),
		.req_last_in  (req.last_in),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.rsp_data_out (rsp.data_out),
		.rsp_last_out (rsp.last_out),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule
